>>> src/llff_pkg.sv
// ----------------------------------------------------------------------------
// llff_pkg
// Shared types and constants for the Lax-Friedrichs flux divergence block.
// ----------------------------------------------------------------------------
package llff_pkg;

  localparam int unsigned QW        = 32;  // Q16.16 word
  localparam int unsigned ACC_W     = 56;  // flux accumulator
  localparam int unsigned PROD_W    = 66;  // 33 x 33 signed product
  localparam int unsigned NUM_W     = 49;  // |diff| << 16
  localparam int unsigned DIV_STEPS = 49;

  localparam logic       CFG_ALPHA      = 1'b0;
  localparam logic       CFG_COMPONENTS = 1'b1;

  localparam logic       OP_LOAD  = 1'b0;
  localparam logic       OP_STATE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MULA,
    S_MULB,
    S_ACCB,
    S_ARD,
    S_AMUL,
    S_AACC,
    S_PRV,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

endpackage

>>> src/llff_if.sv
// ----------------------------------------------------------------------------
// llff_if
// Valid/ready channels for interface items and flux results.
// ----------------------------------------------------------------------------
interface llff_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [31:0] coef_value;
  logic signed [31:0] q_minus;
  logic signed [31:0] q_plus;
  logic [30:0]        cell_width;
  logic               last_component;
  logic               first_interface;

  modport source (output valid, operation, row, col, coef_value, q_minus, q_plus,
                  cell_width, last_component, first_interface, input ready);
  modport sink   (input valid, operation, row, col, coef_value, q_minus, q_plus,
                  cell_width, last_component, first_interface, output ready);
endinterface

interface llff_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] net_flux;
  logic [2:0]         component;
  logic               last_of_cell;

  modport source (output valid, net_flux, component, last_of_cell, input ready);
  modport sink   (input valid, net_flux, component, last_of_cell, output ready);
endinterface

>>> src/linear_lax_friedrichs_flux_divergence.sv
// ----------------------------------------------------------------------------
// linear_lax_friedrichs_flux_divergence
// Linear Lax-Friedrichs interface flux and per-cell flux divergence, Q16.16.
// ----------------------------------------------------------------------------
// A coefficient load or a non-final state component is taken while idle. The
// component that completes an interface starts a sequencer that walks the
// coefficient RAM and the state buffer RAM with one shared 33x33 multiplier:
// per flux component the A*qm + A*qp products over all components, the
// dissipation term, the previous-flux read, then the bit-serial division by
// dx at one quotient bit per cycle (skipped for a zero width) plus the output
// beat (the division and the output beat are skipped on the first interface
// of a sweep or while no previous flux is held). No input beat is taken until
// all of an interface's results are delivered.
module linear_lax_friedrichs_flux_divergence
  import llff_pkg::*;
#(
  parameter int unsigned MAX_COMPONENTS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [30:0]  cfg_data_i,
  llff_in_if.sink      in_i,
  llff_out_if.source   out_o
);

  localparam int unsigned IW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned CD  = MAX_COMPONENTS * MAX_COMPONENTS;
  localparam int unsigned CAW = (CD > 1) ? $clog2(CD) : 1;

  state_e state_q, state_d;

  logic [30:0]   alpha_q, alpha_d;
  logic [3:0]    cip_q, cip_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          have_prev_q, have_prev_d;
  logic [3:0]    prev_p_q, prev_p_d;

  logic [IW-1:0]           i_q, i_d, j_q, j_d;
  logic [3:0]              p_q, p_d, used_q, used_d;
  logic [30:0]             dx_q, dx_d;
  logic                    nout_q, nout_d;
  logic signed [31:0]      a_q, a_d, qp_q, qp_d, f_q, f_d, res_q, res_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                    neg_q, neg_d;
  logic [31:0]             rem_q, rem_d;
  logic [NUM_W-1:0]        quo_q, quo_d;
  logic [5:0]              dcnt_q, dcnt_d;

  logic [3:0]    p_eff, cnt_p1;
  logic          in_acc, completes, load_ok, last_i, last_j;
  logic [CAW-1:0] load_addr, coef_raddr;
  logic [IW-1:0] st_raddr;
  logic [31:0]   coef_rd, prev_rd, prev_val;
  logic [63:0]   st_rd;
  logic signed [32:0] mul_a, mul_b, qdiff, diff;
  logic signed [ACC_W-1:0] term, s_sum, s_half;
  logic [32:0]   mag;
  logic [32:0]   rem_sh;
  logic          ge;

  // effective component count
  always_comb begin
    if (cip_q == 4'd0) begin
      p_eff = 4'd1;
    end else if (cip_q > 4'(MAX_COMPONENTS)) begin
      p_eff = 4'(MAX_COMPONENTS);
    end else begin
      p_eff = cip_q;
    end
  end

  assign in_acc    = in_i.valid && in_i.ready;
  assign cnt_p1    = 4'(cnt_q) + 4'd1;
  assign completes = in_i.last_component || (cnt_p1 >= p_eff);
  assign load_ok   = (4'(in_i.row) < 4'(MAX_COMPONENTS)) &&
                     (4'(in_i.col) < 4'(MAX_COMPONENTS));
  assign load_addr = CAW'(int'(in_i.row) * MAX_COMPONENTS + int'(in_i.col));
  assign coef_raddr = CAW'(int'(i_q) * MAX_COMPONENTS + int'(j_q));
  assign st_raddr  = (state_q == S_ARD) ? i_q : j_q;
  assign last_i    = (4'(i_q) + 4'd1) == p_q;
  assign last_j    = (4'(j_q) + 4'd1) == p_q;

  llff_ram #(.WIDTH(32), .DEPTH(CD)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_i.operation == OP_LOAD) && load_ok),
    .waddr_i (load_addr),
    .wdata_i (in_i.coef_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rd)
  );

  llff_ram #(.WIDTH(64), .DEPTH(MAX_COMPONENTS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_i.operation == OP_STATE)),
    .waddr_i (cnt_q),
    .wdata_i ({in_i.q_plus, in_i.q_minus}),
    .raddr_i (st_raddr),
    .rdata_o (st_rd)
  );

  llff_ram #(.WIDTH(32), .DEPTH(MAX_COMPONENTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_PRV),
    .waddr_i (i_q),
    .wdata_i (f_q),
    .raddr_i (i_q),
    .rdata_o (prev_rd)
  );

  // components beyond the count of the previous interface held a zero flux
  assign prev_val = (4'(i_q) < prev_p_q) ? prev_rd : 32'd0;

  // shared multiplier operands
  assign qdiff = (4'(i_q) < used_q) ?
                 ($signed({st_rd[63], st_rd[63:32]}) - $signed({st_rd[31], st_rd[31:0]})) :
                 33'sd0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MULA: begin
        mul_a = $signed({coef_rd[31], coef_rd});
        mul_b = (4'(j_q) < used_q) ? $signed({st_rd[31], st_rd[31:0]}) : 33'sd0;
      end
      S_MULB: begin
        mul_a = {a_q[31], a_q};
        mul_b = {qp_q[31], qp_q};
      end
      S_AMUL: begin
        mul_a = $signed({2'b00, alpha_q});
        mul_b = qdiff;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign term   = {{(ACC_W-50){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:16]};
  assign s_sum  = acc_q - term;
  assign s_half = s_sum >>> 1;
  assign diff   = $signed({f_q[31], f_q}) - $signed({prev_val[31], prev_val});
  assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {2'b00, dx_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && (in_i.operation == OP_STATE) && completes) state_d = S_RD;
      S_RD:   state_d = S_MULA;
      S_MULA: state_d = S_MULB;
      S_MULB: state_d = S_ACCB;
      S_ACCB: state_d = last_j ? S_ARD : S_RD;
      S_ARD:  state_d = S_AMUL;
      S_AMUL: state_d = S_AACC;
      S_AACC: state_d = S_PRV;
      S_PRV: begin
        if (nout_q) begin
          state_d = last_i ? S_IDLE : S_RD;
        end else if (dx_q == 31'd0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:  if (dcnt_q == 6'd1) state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (out_o.ready) state_d = last_i ? S_IDLE : S_RD;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and register updates
  always_comb begin
    alpha_d     = alpha_q;
    cip_d       = cip_q;
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    prev_p_d    = prev_p_q;
    i_d = i_q;  j_d = j_q;  p_d = p_q;  used_d = used_q;  dx_d = dx_q;
    nout_d = nout_q;  a_d = a_q;  qp_d = qp_q;  f_d = f_q;  res_d = res_q;
    acc_d = acc_q;  prod_d = mul_a * mul_b;  neg_d = neg_q;
    rem_d = rem_q;  quo_d = quo_q;  dcnt_d = dcnt_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ALPHA:      alpha_d = cfg_data_i;
        CFG_COMPONENTS: cip_d   = cfg_data_i[3:0];
        default:        alpha_d = alpha_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.operation == OP_STATE)) begin
          if (completes) begin
            cnt_d  = '0;
            used_d = cnt_p1;
            p_d    = p_eff;
            dx_d   = in_i.cell_width;
            nout_d = in_i.first_interface || !have_prev_q;
            i_d    = '0;
            j_d    = '0;
            acc_d  = '0;
          end else begin
            cnt_d = IW'(cnt_p1);
          end
        end
      end
      S_MULA: begin
        a_d  = coef_rd;
        qp_d = (4'(j_q) < used_q) ? st_rd[63:32] : 32'sd0;
      end
      S_MULB: acc_d = acc_q + term;
      S_ACCB: begin
        acc_d = acc_q + term;
        if (!last_j) j_d = j_q + IW'(1);
      end
      S_AACC: begin
        if (!s_half[ACC_W-1] && (|s_half[ACC_W-2:31])) begin
          f_d = 32'sh7fffffff;
        end else if (s_half[ACC_W-1] && !(&s_half[ACC_W-2:31])) begin
          f_d = 32'sh80000000;
        end else begin
          f_d = s_half[31:0];
        end
      end
      S_PRV: begin
        neg_d  = diff[32];
        quo_d  = {mag[32:0], 16'h0000};
        rem_d  = '0;
        dcnt_d = 6'(DIV_STEPS);
        if (diff > 33'sd0) begin
          res_d = 32'sh80000000;
        end else if (diff < 33'sd0) begin
          res_d = 32'sh7fffffff;
        end else begin
          res_d = 32'sd0;
        end
        if (nout_q) begin
          if (last_i) begin
            have_prev_d = 1'b1;
            prev_p_d    = p_q;
          end else begin
            i_d = i_q + IW'(1);
            j_d = '0;
            acc_d = '0;
          end
        end
      end
      S_DIV: begin
        rem_d  = ge ? 32'(rem_sh - {2'b00, dx_q}) : rem_sh[31:0];
        quo_d  = {quo_q[NUM_W-2:0], ge};
        dcnt_d = dcnt_q - 6'd1;
      end
      S_FIN: begin
        if (neg_q) begin
          res_d = (|quo_q[NUM_W-1:31]) ? 32'sh7fffffff : {1'b0, quo_q[30:0]};
        end else begin
          res_d = (|quo_q[NUM_W-1:31]) ? 32'sh80000000 : 32'(-{1'b0, quo_q[30:0]});
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          if (last_i) begin
            have_prev_d = 1'b1;
            prev_p_d    = p_q;
          end else begin
            i_d = i_q + IW'(1);
            j_d = '0;
            acc_d = '0;
          end
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready         = (state_q == S_IDLE);
    out_o.valid        = (state_q == S_OUT);
    out_o.net_flux     = res_q;
    out_o.component    = 3'(i_q);
    out_o.last_of_cell = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alpha_q     <= 31'd65536;
      cip_q       <= 4'd4;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
      prev_p_q    <= 4'd0;
    end else begin
      state_q     <= state_d;
      alpha_q     <= alpha_d;
      cip_q       <= cip_d;
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
      prev_p_q    <= prev_p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  j_q <= j_d;  p_q <= p_d;  used_q <= used_d;  dx_q <= dx_d;
    nout_q <= nout_d;  a_q <= a_d;  qp_q <= qp_d;  f_q <= f_d;  res_q <= res_d;
    acc_q <= acc_d;  prod_q <= prod_d;  neg_q <= neg_d;
    rem_q <= rem_d;  quo_q <= quo_d;  dcnt_q <= dcnt_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input taken while a result is pending");

  a_last_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_of_cell) |-> ((4'(out_o.component) + 4'd1) == p_q))
    else $error("last_of_cell on wrong component");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_of_cell) |=> in_i.ready)
    else $error("not idle after final result");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dcnt_q != 6'd0))
    else $error("divider step count underflow");

  a_prev_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> have_prev_q)
    else $error("result without previous flux");

endmodule

>>> src/llff_ram.sv
// ----------------------------------------------------------------------------
// llff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
